>>> rtl/sred_pkg.sv
// Shared types, widths and register codes of the scan-row edge point detector.
`default_nettype none

package sred_pkg;

    // Coordinate and derived arithmetic widths
    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;       // neighbor difference, signed
    localparam int SQ_W    = 2 * COORD_W;       // squared component, unsigned
    localparam int PROD_W  = 2 * COORD_W + 1;   // per-axis dot product term, signed
    localparam int NORM_W  = 2 * COORD_W + 2;   // sum of three squares
    localparam int DOT_W   = 2 * COORD_W + 3;   // signed dot product
    localparam int DMAG_W  = 2 * COORD_W + 2;   // magnitude of the dot product

    // Configuration register widths and codes
    localparam int COS_W      = 17;
    localparam int CLR_W      = 16;
    localparam int QSQ_W      = 2 * COS_W;
    localparam int CSQ_W      = 2 * CLR_W;
    localparam int COS_FRAC2  = 32;             // Q1.16 squared
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COSINE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLEARANCE = 1'b1;

    localparam logic [COS_W-1:0] MAX_COSINE_RST    = 17'd13107;
    localparam logic [CLR_W-1:0] MIN_CLEARANCE_RST = 16'd0;

    // Operand slice of the pipelined wide multipliers
    localparam int LIMB_W = 32;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   point_valid;
        logic   row_start;
    } point_t;

    typedef struct packed {
        coord_t edge_x;
        coord_t edge_y;
        coord_t edge_z;
    } edge_t;

    // Window stage output: differences of one valid triple plus its middle point
    typedef struct packed {
        logic                          valid;
        logic [2:0][DIFF_W-1:0]        a;
        logic [2:0][DIFF_W-1:0]        b;
        logic [2:0][COORD_W-1:0]       mid;
    } win_t;

    // Geometry stage output: norms and dot magnitude
    typedef struct packed {
        logic                          valid;
        logic [NORM_W-1:0]             n1;
        logic [NORM_W-1:0]             n2;
        logic [DMAG_W-1:0]             dmag;
        logic [2:0][COORD_W-1:0]       mid;
    } geo_t;

endpackage

`default_nettype wire

>>> rtl/sred_mul.sv
// Two-stage unsigned multiplier built from LIMB_W x LIMB_W partial products.
`default_nettype none

module sred_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0]      p
);
    import sred_pkg::*;

    localparam int NA     = (A_W + LIMB_W - 1) / LIMB_W;
    localparam int NB     = (B_W + LIMB_W - 1) / LIMB_W;
    localparam int PA_W   = NA * LIMB_W;
    localparam int PB_W   = NB * LIMB_W;
    localparam int FULL_W = PA_W + PB_W;
    localparam int P_W    = A_W + B_W;

    logic [PA_W-1:0]     a_pad;
    logic [PB_W-1:0]     b_pad;
    logic [2*LIMB_W-1:0] pp_reg [NA][NB];
    logic [FULL_W-1:0]   acc;
    logic [P_W-1:0]      p_reg;

    assign a_pad = PA_W'(a);
    assign b_pad = PB_W'(b);

    // Stage one: every limb pair multiplied and held
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_pad[i*LIMB_W +: LIMB_W] * b_pad[j*LIMB_W +: LIMB_W];
                end
            end
        end
    end

    // Stage two: align and add the partial products
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (FULL_W'(pp_reg[i][j]) << (LIMB_W * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= acc[P_W-1:0];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/sred_window.sv
// Row window: holds the two previous points and forms neighbor differences.
`default_nettype none

module sred_window (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire sred_pkg::point_t pt,
    output sred_pkg::win_t        win
);
    import sred_pkg::*;

    localparam logic [1:0] FILL_FULL = 2'd2;

    logic                acc;
    logic [COORD_W-1:0]  cur      [3];
    logic [COORD_W-1:0]  p_reg    [3];
    logic [COORD_W-1:0]  m_reg    [3];
    logic [1:0]          hv_reg;
    logic [1:0]          fill_reg;
    logic [1:0]          fill_eff;
    logic [1:0]          fill_next;
    logic                cand;
    win_t                win_reg;
    win_t                win_next;

    assign acc    = adv && in_valid;
    assign cur[0] = pt.point_x;
    assign cur[1] = pt.point_y;
    assign cur[2] = pt.point_z;

    // A row start empties the window before the point is taken in
    assign fill_eff  = pt.row_start ? 2'd0 : fill_reg;
    assign fill_next = (fill_eff == FILL_FULL) ? FILL_FULL : fill_eff + 2'd1;
    assign cand      = (fill_eff == FILL_FULL) && hv_reg[0] && hv_reg[1] && pt.point_valid;

    always_comb
    begin
        win_next.valid = acc && cand;
        for (int k = 0; k < 3; k++)
        begin
            win_next.a[k]   = DIFF_W'($signed(m_reg[k])) - DIFF_W'($signed(p_reg[k]));
            win_next.b[k]   = DIFF_W'($signed(cur[k])) - DIFF_W'($signed(m_reg[k]));
            win_next.mid[k] = m_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_reg[k] <= m_reg[k];
                m_reg[k] <= cur[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg   <= '0;
            fill_reg <= '0;
        end
        else if (acc)
        begin
            hv_reg   <= {pt.point_valid, hv_reg[1]};
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (adv)
        begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

    a_row_start_no_triple: assert property (@(posedge clk) disable iff (!rst_n)
        acc && pt.row_start |=> !win_reg.valid)
        else $error("triple formed across a row start");

    a_missing_point_no_triple: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !pt.point_valid |=> !win_reg.valid)
        else $error("triple formed with a missing point");

    a_triple_has_full_window: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg.valid |-> (fill_reg == FILL_FULL) && hv_reg[1])
        else $error("triple held without a full valid window");

endmodule

`default_nettype wire

>>> rtl/sred_geom.sv
// Vector geometry: component products, then squared norms and dot magnitude.
`default_nettype none

module sred_geom (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire sred_pkg::win_t win,
    output sred_pkg::geo_t      geo
);
    import sred_pkg::*;

    logic [DIFF_W-1:0]       ma       [3];
    logic [DIFF_W-1:0]       mb       [3];
    logic [SQ_W-1:0]         aa_reg   [3];
    logic [SQ_W-1:0]         bb_reg   [3];
    logic [PROD_W-1:0]       ab_reg   [3];
    logic [2:0][COORD_W-1:0] mid_reg;
    logic                    vld_reg;
    logic signed [DOT_W-1:0] dsum;
    logic signed [DOT_W-1:0] dneg;
    geo_t                    geo_reg;

    // Stage two: squares of each component and the signed cross terms
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ma[k] = win.a[k][DIFF_W-1] ? -win.a[k] : win.a[k];
            mb[k] = win.b[k][DIFF_W-1] ? -win.b[k] : win.b[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                aa_reg[k] <= SQ_W'(ma[k][COORD_W-1:0]) * SQ_W'(ma[k][COORD_W-1:0]);
                bb_reg[k] <= SQ_W'(mb[k][COORD_W-1:0]) * SQ_W'(mb[k][COORD_W-1:0]);
                ab_reg[k] <= PROD_W'($signed(win.a[k])) * PROD_W'($signed(win.b[k]));
            end
            mid_reg <= win.mid;
        end
    end

    // Stage three: sum over the three axes
    assign dsum = DOT_W'($signed(ab_reg[0])) + DOT_W'($signed(ab_reg[1]))
                + DOT_W'($signed(ab_reg[2]));
    assign dneg = -dsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            geo_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg       <= win.valid;
            geo_reg.valid <= vld_reg;
            geo_reg.n1    <= NORM_W'(aa_reg[0]) + NORM_W'(aa_reg[1]) + NORM_W'(aa_reg[2]);
            geo_reg.n2    <= NORM_W'(bb_reg[0]) + NORM_W'(bb_reg[1]) + NORM_W'(bb_reg[2]);
            geo_reg.dmag  <= dsum[DOT_W-1] ? dneg[DMAG_W-1:0] : dsum[DMAG_W-1:0];
            geo_reg.mid   <= mid_reg;
        end
    end

    assign geo = geo_reg;

endmodule

`default_nettype wire

>>> rtl/scan_row_edge_point_detector.sv
// Top level of the scan-row edge point detector: config, wide products, decision.
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_ready     in_data   (sred_pkg::point_t)
//  out       output     out_valid / out_ready   out_data  (sred_pkg::edge_t)
//  cfg       input      cfg_we                  cfg_idx, cfg_wdata
//
// One point is taken every cycle while the output side keeps up; a transfer
// on the input shows its edge point, if any, on out_valid at the end of the pipeline.
// The depth comes from the two chained two-stage wide multipliers that form
// q^2 * |v1|^2 * |v2|^2. Reset clears the window, all valid bits and the
// config registers to their defaults. When out_data is held by out_ready low,
// the whole pipeline and in_ready hold with it; nothing is dropped.
`default_nettype none

module scan_row_edge_point_detector (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire sred_pkg::point_t                   in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output sred_pkg::edge_t                         out_data,
    input  wire logic                               cfg_we,
    input  wire logic [sred_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [sred_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import sred_pkg::*;

    localparam int N12_W = 2 * NORM_W;
    localparam int D2_W  = 2 * DMAG_W;
    localparam int CMP_W = QSQ_W + N12_W;

    typedef struct packed {
        logic                    clr_ok;
        logic [2:0][COORD_W-1:0] mid;
    } side_t;

    logic              adv;
    logic [COS_W-1:0]  cos_reg;
    logic [CLR_W-1:0]  clr_reg;
    logic [QSQ_W-1:0]  qsq_reg;
    logic [CSQ_W-1:0]  csq_reg;
    win_t              win;
    geo_t              geo;
    logic              clr_ok;
    logic [N12_W-1:0]  n12;
    logic [D2_W-1:0]   d2;
    logic [CMP_W-1:0]  rhs;
    logic [CMP_W-1:0]  lhs;
    logic [3:0]        vld_reg;
    side_t             side_reg [4];
    logic [D2_W-1:0]   d2_reg   [2];
    logic              is_edge;
    logic              out_valid_reg;
    edge_t             out_data_reg;

    // Advance the whole pipeline unless a finished result is still waiting
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Config registers; writes must arrive only while nothing is in flight (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= MAX_COSINE_RST;
            clr_reg <= MIN_CLEARANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_MAX_COSINE:    cos_reg <= cfg_wdata[COS_W-1:0];
                CFG_MIN_CLEARANCE: clr_reg <= cfg_wdata[CLR_W-1:0];
                default:           ;
            endcase
        end
    end

    // Squared thresholds, refreshed every cycle and settled long before use
    always_ff @(posedge clk)
    begin
        qsq_reg <= QSQ_W'(cos_reg) * QSQ_W'(cos_reg);
        csq_reg <= CSQ_W'(clr_reg) * CSQ_W'(clr_reg);
    end

    // Stage one: window and differences
    sred_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .pt       (in_data),
        .win      (win)
    );

    // Stages two and three: norms and dot magnitude
    sred_geom u_geom (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .win   (win),
        .geo   (geo)
    );

    // Stages four and five: |v1|^2 * |v2|^2 and dot^2
    sred_mul #(
        .A_W (NORM_W),
        .B_W (NORM_W)
    ) u_mul_nn (
        .clk (clk),
        .en  (adv),
        .a   (geo.n1),
        .b   (geo.n2),
        .p   (n12)
    );

    sred_mul #(
        .A_W (DMAG_W),
        .B_W (DMAG_W)
    ) u_mul_dd (
        .clk (clk),
        .en  (adv),
        .a   (geo.dmag),
        .b   (geo.dmag),
        .p   (d2)
    );

    // Stages six and seven: scale the norm product by the squared cosine
    sred_mul #(
        .A_W (QSQ_W),
        .B_W (N12_W)
    ) u_mul_qn (
        .clk (clk),
        .en  (adv),
        .a   (qsq_reg),
        .b   (n12),
        .p   (rhs)
    );

    // Both vectors must clear the minimum length
    assign clr_ok = (CMP_W'(geo.n1) >= CMP_W'(csq_reg)) && (CMP_W'(geo.n2) >= CMP_W'(csq_reg));

    // Side band: valid, clearance result and middle point ride along the multipliers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], geo.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].clr_ok <= clr_ok;
            side_reg[0].mid    <= geo.mid;
            for (int s = 1; s < 4; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            d2_reg[0] <= d2;
            d2_reg[1] <= d2_reg[0];
        end
    end

    // Final decision: dot^2 * 2^32 < q^2 * n1 * n2, strict so zero vectors fail
    assign lhs     = CMP_W'(d2_reg[1]) << COS_FRAC2;
    assign is_edge = vld_reg[3] && side_reg[3].clr_ok && (lhs < rhs);

    // Output register parts the pipeline from the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= is_edge;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.edge_x <= side_reg[3].mid[0];
            out_data_reg.edge_y <= side_reg[3].mid[1];
            out_data_reg.edge_z <= side_reg[3].mid[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
